// ===== rtl/ffha_pkg.sv =====
// ----------------------------------------------------------------------------
// ffha_pkg
// Shared types and constants of the first-fit heap allocator: heap geometry,
// operation and status codes, the request and result words and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package ffha_pkg;

	// Heap geometry. Offsets on the ports are 10 bits, which fixes the heap.
	localparam int HEAP_BYTES    = 1024;
	localparam int HEADER_BYTES  = 16;
	localparam int GRANULE_BYTES = 8;
	localparam int NGRAN         = HEAP_BYTES / GRANULE_BYTES;
	localparam int HDR_GRAN      = (HEADER_BYTES + GRANULE_BYTES - 1) / GRANULE_BYTES;
	localparam int GRAN_SHIFT    = $clog2(GRANULE_BYTES);

	// Field widths of the words on the ports.
	localparam int BYTES_W = 11;
	localparam int OFF_W   = 10;
	localparam int STAT_W  = 2;

	// Internal widths: a granule index, a link (index plus the null value)
	// and a rounded request in granules.
	localparam int ADDR_W = $clog2(NGRAN);
	localparam int LINK_W = ADDR_W + 1;
	localparam int SIZE_W = LINK_W;
	localparam int REQ_W  = BYTES_W - GRAN_SHIFT + 1;

	localparam logic [LINK_W-1:0] NIL_LINK  = LINK_W'(NGRAN);
	localparam logic [SIZE_W-1:0] HDR_G     = SIZE_W'(HDR_GRAN);
	localparam logic [SIZE_W-1:0] INIT_SIZE = SIZE_W'(NGRAN - HDR_GRAN);
	localparam logic [LINK_W-1:0] STEP_MAX  = LINK_W'(NGRAN);
	localparam logic [OFF_W-1:0]  MIN_OFF   = OFF_W'(HDR_GRAN * GRANULE_BYTES);

	// Operation codes.
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// Status codes.
	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
	localparam logic [STAT_W-1:0] ST_BADFREE = 2'd2;

	// Request word.
	typedef struct packed {
		logic               op;
		logic [BYTES_W-1:0] alloc_bytes;
		logic [OFF_W-1:0]   free_offset;
	} ffha_req_t;

	// Result word.
	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [OFF_W-1:0]  payload_offset;
	} ffha_res_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic              load;      // take the request, start a walk at the head
		logic              advance;   // step to the next free block
		logic              wr_split;  // write the header of the split-off remainder
		logic              wr_unlink; // unlink the whole block
		logic              wr_hdr;    // shrink the granted block, link the remainder
		logic              wr_insert; // link the freed block after its predecessor
		logic              wr_merge;  // finish the freed header, merging if adjacent
		logic              finish;    // register the result word
		logic              grant;     // the result carries a payload offset
		logic [STAT_W-1:0] status;
	} ffha_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic req_free;  // the request on the port is a free
		logic req_bad;   // the free offset on the port is misaligned or too low
		logic walk_end;  // allocate walk ran off the list or out of steps
		logic fits;      // current block is large enough
		logic split_ok;  // remainder can hold a header and a payload granule
		logic free_more; // free walk has not reached the freed header yet
		logic dup;       // the freed header is already on the list
	} ffha_stat_t;

endpackage

// ===== rtl/first_fit_heap_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_heap_allocator
// First-fit allocator over a 1024-byte heap with an address-ordered free list
// kept in block headers; answers allocate and free requests.
// ----------------------------------------------------------------------------
// A request word is taken when start is high and busy is low. Each request
// gives exactly one result word, shown for one cycle with done high; the
// receiver cannot stall it, so it must take the word in that cycle. An
// allocate visits the free list one block per cycle through the registered
// read port of the header stores and answers at the first block that fits,
// or with no fit when the walk runs off the list or stops after 128 blocks.
// A split keeps busy high in S_ASPLIT to write the header. A free walks
// the list the same way up to the first block at or past the freed header
// or the end of the list, and then links and merges the freed block; a
// misaligned or too-low offset is answered in the cycle after acceptance.
// A new request may be accepted in the cycle done is high, except after a
// split, where busy stays high through S_ASPLIT. No clearing pass runs
// after reset: entries never written read as their reset values.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator import ffha_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  ffha_req_t request,
	output logic      done,
	output ffha_res_t result
);

	ffha_cmd_t  cmd;
	ffha_stat_t stat;

	// Sequencer.
	ffha_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// Header stores, walk registers and result word.
	ffha_dp u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.request (request),
		.cmd     (cmd),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule

// ===== rtl/ffha_dp.sv =====
// ----------------------------------------------------------------------------
// ffha_dp
// Datapath of the allocator: the header stores (sizes and links), the list
// head, the walk registers and the result word.
// ----------------------------------------------------------------------------
module ffha_dp import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ffha_req_t  request,
	input  ffha_cmd_t  cmd,
	output ffha_stat_t stat,
	output logic       done,
	output ffha_res_t  result
);

	// Header stores and the written marks that stand in for their reset.
	logic [SIZE_W-1:0] size_mem [NGRAN];
	logic [LINK_W-1:0] link_mem [NGRAN];
	logic [NGRAN-1:0]  size_vld_q;
	logic [NGRAN-1:0]  link_vld_q;

	logic [SIZE_W-1:0] size_rd_q;
	logic [LINK_W-1:0] link_rd_q;
	logic              size_rv_q;
	logic              link_rv_q;
	logic [ADDR_W-1:0] rd_addr_q;

	// Walk registers.
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] cur_q;
	logic [LINK_W-1:0] prev_q;
	logic [LINK_W-1:0] steps_q;
	logic [REQ_W-1:0]  req_q;
	logic [ADDR_W-1:0] h_q;
	logic [SIZE_W-1:0] csz_q;
	logic [LINK_W-1:0] clink_q;

	ffha_res_t result_q;
	logic      done_q;

	logic [SIZE_W-1:0]  size_rd;
	logic [LINK_W-1:0]  link_rd;
	logic               rd_en;
	logic [ADDR_W-1:0]  rd_addr;
	logic [BYTES_W:0]   bytes_sum;
	logic [REQ_W-1:0]   req_gran;
	logic [ADDR_W-1:0]  h_gran;
	logic [OFF_W:0]     nb_full;
	logic [SIZE_W-1:0]  rem;
	logic [SIZE_W:0]    h_end;
	logic               merge;
	logic [SIZE_W-1:0]  merged_size;
	logic [LINK_W+GRAN_SHIFT-1:0] pay_full;

	logic              sw_en;
	logic [ADDR_W-1:0] sw_addr;
	logic [SIZE_W-1:0] sw_data;
	logic              lw_en;
	logic [ADDR_W-1:0] lw_addr;
	logic [LINK_W-1:0] lw_data;
	logic              head_we;
	logic [LINK_W-1:0] head_d;
	logic              link_sel;
	logic [LINK_W-1:0] link_val;

	// Read data; an entry never written reads as its reset value.
	assign size_rd = size_rv_q ? size_rd_q :
		((rd_addr_q == '0) ? INIT_SIZE : '0);
	assign link_rd = link_rv_q ? link_rd_q : NIL_LINK;

	// Request decode: rounded size in granules and header granule of a free.
	assign bytes_sum = {1'b0, request.alloc_bytes} + (BYTES_W+1)'(GRANULE_BYTES - 1);
	assign req_gran  = bytes_sum[BYTES_W:GRAN_SHIFT];
	assign h_gran    = request.free_offset[OFF_W-1:GRAN_SHIFT] - ADDR_W'(HDR_GRAN);

	// Split arithmetic on the block under the walk.
	assign nb_full = (OFF_W+1)'(cur_q) + (OFF_W+1)'(HDR_GRAN) + (OFF_W+1)'(req_q);
	assign rem     = size_rd - req_q[SIZE_W-1:0];

	// Merge test: the freed block ends exactly where the following one starts.
	assign h_end       = (SIZE_W+1)'(h_q) + (SIZE_W+1)'(HDR_GRAN) + (SIZE_W+1)'(size_rd);
	assign merge       = (cur_q < NIL_LINK) && (h_end == (SIZE_W+1)'(cur_q));
	assign merged_size = size_rd + csz_q + HDR_G;

	// Granted payload offset, reduced to the port width.
	assign pay_full = {cur_q + HDR_G, GRAN_SHIFT'(0)};

	// Status to the controller.
	always_comb begin
		stat.req_free  = (request.op == OP_FREE);
		stat.req_bad   = (request.free_offset[GRAN_SHIFT-1:0] != '0) ||
			(request.free_offset < MIN_OFF);
		stat.walk_end  = (cur_q >= NIL_LINK) || (steps_q == STEP_MAX);
		stat.fits      = ({1'b0, size_rd} >= req_q);
		stat.split_ok  = (rem > HDR_G) && ((nb_full + (OFF_W+1)'(HDR_GRAN)) <
			(OFF_W+1)'(NGRAN));
		stat.free_more = (cur_q < LINK_W'(h_q)) && (steps_q != STEP_MAX);
		stat.dup       = (cur_q == LINK_W'(h_q));
	end

	// Read port address.
	always_comb begin
		rd_en = cmd.load || cmd.advance || cmd.wr_insert;
		if (cmd.load) begin
			rd_addr = head_q[ADDR_W-1:0];
		end else if (cmd.advance) begin
			rd_addr = link_rd[ADDR_W-1:0];
		end else begin
			rd_addr = h_q;
		end
	end

	// Write ports. A link to a predecessor goes to the head when there is none.
	always_comb begin
		sw_en    = 1'b0;
		sw_addr  = cur_q[ADDR_W-1:0];
		sw_data  = req_q[SIZE_W-1:0];
		lw_en    = 1'b0;
		lw_addr  = prev_q[ADDR_W-1:0];
		lw_data  = link_rd;
		head_we  = 1'b0;
		head_d   = link_rd;
		link_sel = 1'b0;
		link_val = link_rd;
		if (cmd.wr_split) begin
			sw_en   = 1'b1;
			sw_addr = nb_full[ADDR_W-1:0];
			sw_data = rem - HDR_G;
			lw_en   = 1'b1;
			lw_addr = nb_full[ADDR_W-1:0];
			lw_data = link_rd;
		end
		if (cmd.wr_unlink) begin
			link_sel = 1'b1;
			link_val = link_rd;
		end
		if (cmd.wr_hdr) begin
			sw_en    = 1'b1;
			sw_addr  = cur_q[ADDR_W-1:0];
			sw_data  = req_q[SIZE_W-1:0];
			link_sel = 1'b1;
			link_val = nb_full[LINK_W-1:0];
		end
		if (cmd.wr_insert) begin
			link_sel = 1'b1;
			link_val = LINK_W'(h_q);
		end
		if (cmd.wr_merge) begin
			lw_en   = 1'b1;
			lw_addr = h_q;
			if (merge) begin
				sw_en   = 1'b1;
				sw_addr = h_q;
				sw_data = merged_size;
				lw_data = clink_q;
			end else begin
				lw_data = (cur_q < NIL_LINK) ? cur_q : NIL_LINK;
			end
		end
		if (link_sel) begin
			if (prev_q < NIL_LINK) begin
				lw_en   = 1'b1;
				lw_addr = prev_q[ADDR_W-1:0];
				lw_data = link_val;
			end else begin
				head_we = 1'b1;
				head_d  = link_val;
			end
		end
	end

	// Header stores.
	always_ff @(posedge clk) begin
		if (sw_en) begin
			size_mem[sw_addr] <= sw_data;
		end
		if (lw_en) begin
			link_mem[lw_addr] <= lw_data;
		end
		if (rd_en) begin
			size_rd_q <= size_mem[rd_addr];
			link_rd_q <= link_mem[rd_addr];
		end
	end

	// Written marks, list head and read bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_vld_q <= '0;
			link_vld_q <= '0;
			size_rv_q  <= 1'b0;
			link_rv_q  <= 1'b0;
			rd_addr_q  <= '0;
			head_q     <= '0;
			done_q     <= 1'b0;
		end else begin
			if (sw_en) begin
				size_vld_q[sw_addr] <= 1'b1;
			end
			if (lw_en) begin
				link_vld_q[lw_addr] <= 1'b1;
			end
			if (rd_en) begin
				size_rv_q <= size_vld_q[rd_addr];
				link_rv_q <= link_vld_q[rd_addr];
				rd_addr_q <= rd_addr;
			end
			if (head_we) begin
				head_q <= head_d;
			end
			done_q <= cmd.finish;
		end
	end

	// Walk registers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_q   <= head_q;
			prev_q  <= NIL_LINK;
			steps_q <= '0;
			req_q   <= req_gran;
			h_q     <= h_gran;
		end else if (cmd.advance) begin
			prev_q  <= cur_q;
			cur_q   <= link_rd;
			steps_q <= steps_q + 1'b1;
		end
		if (cmd.wr_insert) begin
			csz_q   <= size_rd;
			clink_q <= link_rd;
		end
	end

	// Result word.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result_q.status         <= cmd.status;
			result_q.payload_offset <= cmd.grant ? pay_full[OFF_W-1:0] : '0;
		end
	end

	assign done   = done_q;
	assign result = result_q;

endmodule

// ===== rtl/ffha_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffha_ctrl
// Controller of the allocator: sequences the list walk and the header
// updates of an allocate or a free.
// ----------------------------------------------------------------------------
module ffha_ctrl import ffha_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  ffha_stat_t stat,
	output ffha_cmd_t  cmd,
	output logic       busy
);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_AWALK  = 5'b00010,
		S_ASPLIT = 5'b00100,
		S_FWALK  = 5'b01000,
		S_FMERGE = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and commands.
	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.status = ST_OK;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (stat.req_free && stat.req_bad) begin
						cmd.finish = 1'b1;
						cmd.status = ST_BADFREE;
					end else begin
						cmd.load = 1'b1;
						state_d  = stat.req_free ? S_FWALK : S_AWALK;
					end
				end
			end
			S_AWALK: begin
				if (stat.walk_end) begin
					cmd.finish = 1'b1;
					cmd.status = ST_NOFIT;
					state_d    = S_IDLE;
				end else if (stat.fits) begin
					cmd.finish = 1'b1;
					cmd.grant  = 1'b1;
					if (stat.split_ok) begin
						cmd.wr_split = 1'b1;
						state_d      = S_ASPLIT;
					end else begin
						cmd.wr_unlink = 1'b1;
						state_d       = S_IDLE;
					end
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_ASPLIT: begin
				cmd.wr_hdr = 1'b1;
				state_d    = S_IDLE;
			end
			S_FWALK: begin
				if (stat.free_more) begin
					cmd.advance = 1'b1;
				end else if (stat.dup) begin
					cmd.finish = 1'b1;
					cmd.status = ST_BADFREE;
					state_d    = S_IDLE;
				end else begin
					cmd.wr_insert = 1'b1;
					state_d       = S_FMERGE;
				end
			end
			S_FMERGE: begin
				cmd.wr_merge = 1'b1;
				cmd.finish   = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Busy stays high in S_ASPLIT, where a split allocate writes its header while its result is shown.
	assign busy = (state_q != S_IDLE);

endmodule

// ===== tb/tb_first_fit_heap_allocator.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_fit_heap_allocator
// Self-checking testbench for the first-fit heap allocator. A behavioral copy
// of the free list predicts the result word of every accepted request. A
// checker compares each result word with the oldest prediction. Stimulus is a
// short directed set followed by well-formed random traffic and then random
// frees that corrupt the heap on purpose.
// ----------------------------------------------------------------------------
module tb_first_fit_heap_allocator import ffha_pkg::*; ();

	logic      clk     = 1'b0;
	logic      arst_n  = 1'b0;
	logic      start   = 1'b0;
	ffha_req_t request = '0;
	logic      busy;
	logic      done;
	ffha_res_t result;

	// Behavioral copy of the heap headers and the free list head.
	logic [SIZE_W-1:0] gran_size [NGRAN];
	logic [LINK_W-1:0] gran_link [NGRAN];
	int                free_list_head;

	// Result words still owed by the block, oldest first.
	ffha_res_t awaited_results[$];
	// Payload offsets granted and not yet released.
	int        live_offsets[$];

	int mismatches      = 0;
	int results_checked = 0;
	int grants          = 0;
	int no_fits         = 0;
	int frees_taken     = 0;
	int frees_refused   = 0;
	bit steady_feed     = 1'b0;

	first_fit_heap_allocator i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	always #5 clk = ~clk;

	// Safety net against a hung handshake.
	initial begin
		#(5_000_000);
		$display("TEST FAILED");
		$finish;
	end

	// Point the predecessor, or the head when there is none, at a header.
	function automatic void relink(input int prev, input int target);
		if (prev < NGRAN) begin
			gran_link[prev] = LINK_W'(target);
		end else begin
			free_list_head = target;
		end
	endfunction

	// Apply one request to the heap copy and return the result word it gives.
	function automatic ffha_res_t heap_step_result(input ffha_req_t word);
		ffha_res_t outcome;
		int need;
		int cur;
		int prev;
		int steps;
		int rest;
		int split_at;
		int off;
		int hdr;
		outcome.status         = ST_NOFIT;
		outcome.payload_offset = '0;
		cur   = free_list_head;
		prev  = NGRAN;
		steps = 0;
		if (word.op == OP_ALLOC) begin
			// First fit: split when the remainder holds a header and a granule.
			need = (int'(word.alloc_bytes) + GRANULE_BYTES - 1) / GRANULE_BYTES;
			while (cur < NGRAN && steps < NGRAN) begin
				if (int'(gran_size[cur]) >= need) begin
					rest     = int'(gran_size[cur]) - need;
					split_at = cur + HDR_GRAN + need;
					if (rest > HDR_GRAN && split_at + HDR_GRAN < NGRAN) begin
						gran_size[split_at] = SIZE_W'(rest - HDR_GRAN);
						gran_link[split_at] = gran_link[cur];
						gran_size[cur]      = SIZE_W'(need);
						relink(prev, split_at);
					end else begin
						relink(prev, int'(gran_link[cur]));
					end
					outcome.status         = ST_OK;
					outcome.payload_offset = OFF_W'((cur + HDR_GRAN) * GRANULE_BYTES);
					return outcome;
				end
				prev = cur;
				cur  = int'(gran_link[cur]);
				steps++;
			end
			return outcome;
		end
		// Free: reject bad offsets, then insert in address order.
		outcome.status = ST_BADFREE;
		off = int'(word.free_offset);
		if (off % GRANULE_BYTES != 0 || off < HDR_GRAN * GRANULE_BYTES || off >= HEAP_BYTES) begin
			return outcome;
		end
		hdr = off / GRANULE_BYTES - HDR_GRAN;
		while (cur < NGRAN && cur < hdr && steps < NGRAN) begin
			prev = cur;
			cur  = int'(gran_link[cur]);
			steps++;
		end
		if (cur == hdr) begin
			return outcome;
		end
		relink(prev, hdr);
		gran_link[hdr] = (cur < NGRAN) ? LINK_W'(cur) : NIL_LINK;
		// Merge only with the free block that directly follows.
		if (cur < NGRAN && hdr + HDR_GRAN + int'(gran_size[hdr]) == cur) begin
			gran_size[hdr] = gran_size[hdr] + gran_size[cur] + HDR_G;
			gran_link[hdr] = gran_link[cur];
		end
		outcome.status = ST_OK;
		return outcome;
	endfunction

	// Send one request word, predict its result and track live blocks.
	task automatic send_word(input logic op, input int bytes, input int off);
		ffha_req_t word;
		ffha_res_t outcome;
		int        gap;
		int        i;
		gap         = steady_feed ? 0 : $urandom_range(0, 4);
		word.op     = op;
		word.alloc_bytes = (op == OP_ALLOC) ? BYTES_W'(bytes) : BYTES_W'($urandom_range(0, 1024));
		word.free_offset = (op == OP_FREE) ? OFF_W'(off) : OFF_W'($urandom_range(0, 1023));
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= word;
		do @(posedge clk); while (busy);
		outcome = heap_step_result(word);
		awaited_results.push_back(outcome);
		if (op == OP_ALLOC) begin
			if (outcome.status == ST_OK) begin
				grants++;
				live_offsets.push_back(int'(outcome.payload_offset));
			end else begin
				no_fits++;
			end
		end else if (outcome.status == ST_OK) begin
			frees_taken++;
			for (i = 0; i < live_offsets.size(); i++) begin
				if (live_offsets[i] == off) begin
					live_offsets.delete(i);
					break;
				end
			end
		end else begin
			frees_refused++;
		end
	endtask

	// Hold the sender off until every owed result word has come back.
	task automatic wait_all_results();
		start <= 1'b0;
		do @(posedge clk); while (awaited_results.size() != 0);
	endtask

	// Pick a random live payload offset, or zero when none is live.
	function automatic int pick_live();
		if (live_offsets.size() == 0) begin
			return 0;
		end
		return live_offsets[$urandom_range(0, live_offsets.size() - 1)];
	endfunction

	// Whole heap, empty list, oversize, zero-byte and small allocations, and a free.
	task automatic test_alloc_edges();
		send_word(OP_ALLOC, 1008, 0);
		send_word(OP_ALLOC, 0, 0);
		send_word(OP_FREE, 0, 16);
		send_word(OP_ALLOC, 1024, 0);
		send_word(OP_ALLOC, 0, 0);
		send_word(OP_ALLOC, 1, 0);
		send_word(OP_ALLOC, 1023, 0);
		send_word(OP_ALLOC, 64, 0);
	endtask

	// Misaligned, too low and edge offsets, double frees, never-granted blocks.
	task automatic test_free_checks();
		send_word(OP_FREE, 0, 3);
		send_word(OP_FREE, 0, 0);
		send_word(OP_FREE, 0, 8);
		send_word(OP_FREE, 0, 1023);
		send_word(OP_FREE, 0, 32);
		send_word(OP_FREE, 0, 32);
		send_word(OP_FREE, 0, 1016);
		send_word(OP_FREE, 0, 512);
		send_word(OP_ALLOC, 1000, 0);
		send_word(OP_FREE, 0, 16);
		send_word(OP_ALLOC, 8, 0);
	endtask

	// Well-formed traffic: allocations and frees of live blocks, with some
	// rejected frees that leave the heap untouched.
	task automatic test_random_clean(input int count);
		int i;
		int pick;
		int off;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				steady_feed = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 50 || live_offsets.size() == 0) begin
				send_word(OP_ALLOC, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1024)
				                                              : $urandom_range(0, 96), 0);
			end else if (pick < 90) begin
				off = pick_live();
				send_word(OP_FREE, 0, off);
				// A repeat right after the free finds the header on the list.
				if ($urandom_range(0, 7) == 0) begin
					send_word(OP_FREE, 0, off);
				end
			end else if (pick < 95) begin
				send_word(OP_FREE, 0, $urandom_range(0, 15));
			end else begin
				send_word(OP_FREE, 0, $urandom_range(0, 1023) | (1 << $urandom_range(0, 2)));
			end
		end
	endtask

	// Frees of arbitrary offsets that corrupt the list, mixed with normal use.
	task automatic test_random_noise(input int count);
		int i;
		int pick;
		int off;
		for (i = 0; i < count; i++) begin
			if (i % 40 == 0) begin
				steady_feed = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				send_word(OP_ALLOC, $urandom_range(0, 128), 0);
			end else if (pick < 70 && live_offsets.size() != 0) begin
				send_word(OP_FREE, 0, pick_live());
			end else begin
				off = $urandom_range(0, 1023);
				if ($urandom_range(0, 2) != 0) begin
					off = off & ~(GRANULE_BYTES - 1);
				end
				send_word(OP_FREE, 0, off);
			end
		end
	endtask

	// Compare every result word with the oldest prediction.
	always @(posedge clk) begin : check_results
		ffha_res_t want;
		if (arst_n && done) begin
			results_checked++;
			if (awaited_results.size() == 0) begin
				if (mismatches < 10) begin
					$display("%0t: result word with no request pending: status %0d offset %0d",
					         $time, result.status, result.payload_offset);
				end
				mismatches++;
			end else begin
				want = awaited_results.pop_front();
				if (result.status !== want.status
				    || result.payload_offset !== want.payload_offset) begin
					if (mismatches < 10) begin
						$display("%0t: mismatch: status exp %0d got %0d, offset exp %0d got %0d",
						         $time, want.status, result.status,
						         want.payload_offset, result.payload_offset);
					end
					mismatches++;
				end
			end
		end
	end

	// Reset, run the tests in turn and report.
	initial begin
		for (int g = 0; g < NGRAN; g++) begin
			gran_size[g] = '0;
			gran_link[g] = NIL_LINK;
		end
		gran_size[0]   = INIT_SIZE;
		free_list_head = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_alloc_edges();
		test_free_checks();
		wait_all_results();
		test_random_clean(450);
		wait_all_results();
		test_random_noise(230);
		wait_all_results();
		repeat (200) @(posedge clk);
		$display("Covered %0d grants, %0d no-fit answers, %0d accepted and %0d refused frees.",
		         grants, no_fits, frees_taken, frees_refused);
		$display("Checked %0d result words, %0d mismatches.", results_checked, mismatches);
		if (mismatches == 0 && awaited_results.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
